>>> rtl/gmed_pkg.sv
package gmed_pkg;

  // Channel counts and counter width
  localparam int IN_CH  = 8;
  localparam int OUT_CH = 8;
  localparam int CNT_W  = 16;

  // Valid channel masks
  localparam logic [7:0] IN_MASK  = 8'((9'd1 << IN_CH) - 9'd1);
  localparam logic [7:0] OUT_MASK = 8'((9'd1 << OUT_CH) - 9'd1);

  // Register indexes (byte address = 8 * index)
  localparam logic [1:0] REG_ENABLED = 2'd0;
  localparam logic [1:0] REG_RISING  = 2'd1;
  localparam logic [1:0] REG_ALWAYS  = 2'd2;
  localparam logic [1:0] REG_LINKS   = 2'd3;

  typedef struct packed {
    logic [7:0] input_levels;
    logic [7:0] output_levels;
  } gmed_in_t;

  typedef struct packed {
    logic        changed;
    logic [7:0]  edge_mask;
    logic [15:0] edge_count_ch0;
    logic [15:0] edge_count_ch1;
    logic [15:0] edge_count_ch2;
    logic [15:0] edge_count_ch3;
    logic [15:0] edge_count_ch4;
    logic [15:0] edge_count_ch5;
    logic [15:0] edge_count_ch6;
    logic [15:0] edge_count_ch7;
  } gmed_out_t;

  // Per-lane configuration slice
  typedef struct packed {
    logic       enabled;
    logic       rising;
    logic       always_on;
    logic [7:0] links;
  } gmed_lane_cfg_t;

  // Per-lane poll controls
  typedef struct packed {
    logic clear;
    logic step;
    logic cur_level;
    logic last_level;
  } gmed_lane_ctl_t;

  // Low 16 bits of a counter, zero extended if narrower
  function automatic logic [15:0] cnt_field(logic [CNT_W-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[15:0];
  endfunction

endpackage

>>> rtl/gmed_lane.sv
module gmed_lane (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gmed_pkg::gmed_lane_cfg_t cfg,
  input  gmed_pkg::gmed_lane_ctl_t ctl,
  input  logic [7:0]              output_levels,
  output logic                    edge_hit,
  output logic [gmed_pkg::CNT_W-1:0] count
);
  import gmed_pkg::*;

  logic             det;
  logic             gate;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  // Polarity-selected edge on an enabled channel
  assign det = cfg.enabled &
               (cfg.rising ? (ctl.cur_level & ~ctl.last_level)
                           : (ctl.last_level & ~ctl.cur_level));

  // Gate by always-enable or any linked output high
  assign gate     = cfg.always_on | (|(cfg.links & output_levels & OUT_MASK));
  assign edge_hit = det & gate;

  // Saturating counter
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctl.clear) begin
      cnt_nxt = '0;
    end else if (ctl.step && edge_hit && !(&cnt_r)) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign count = cnt_nxt;

endmodule

>>> rtl/gmed_skid.sv
module gmed_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  gmed_pkg::gmed_out_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output gmed_pkg::gmed_out_t out_data
);
  import gmed_pkg::*;

  logic      main_valid_r;
  logic      skid_valid_r;
  gmed_out_t main_data_r;
  gmed_out_t skid_data_r;
  logic      take;

  assign take      = main_valid_r & ~out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

  // Control: main register feeds the port, skid catches one transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (take || !main_valid_r) begin
      main_valid_r <= skid_valid_r | push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (take || !main_valid_r) begin
      main_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

>>> rtl/gated_multichannel_edge_detector.sv
// Gated multichannel edge detector.
//
// Input channel (in_valid / in_stall / in_data): one poll transaction carries
// the sampled input levels and the current output levels. Result channel
// (out_valid / out_stall / out_data): one result per poll with the changed
// flag, the mask of counted edges and eight saturating edge counters.
// Configuration: APB-style port, 64-bit data, registers at byte addresses
// 0, 8, 16, 24 (enabled inputs, rising polarity, always-enabled, link map).
// Any register write clears the poll history and all counters.
//
// Throughput is one poll per cycle while in_stall is low: eight lanes detect
// edges in parallel and the history and counter update closes within the
// accepting cycle. A result is registered in the main or, on a stall, the skid
// entry of a two-entry output buffer that absorbs a stalled receiver; in_stall
// rises only when both entries are full, and no result is dropped or repeated.
//
// Reset (rst_n, synchronous, active low) restores the register defaults,
// clears history, counters and the output buffer. The first poll after
// reset or after a write reports changed with an empty edge mask.
module gated_multichannel_edge_detector (
  input  logic                clk,
  input  logic                rst_n,
  // poll input
  input  logic                in_valid,
  output logic                in_stall,
  input  gmed_pkg::gmed_in_t  in_data,
  // results
  output logic                out_valid,
  input  logic                out_stall,
  output gmed_pkg::gmed_out_t out_data,
  // configuration
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [4:0]          cfg_paddr,
  input  logic [63:0]         cfg_pwdata,
  output logic [63:0]         cfg_prdata,
  output logic                cfg_pready
);
  import gmed_pkg::*;

  logic [7:0]  enabled_r;
  logic [7:0]  rising_r;
  logic [7:0]  always_r;
  logic [63:0] links_r;
  logic [7:0]  last_in_r;
  logic [7:0]  last_out_r;
  logic        hist_valid_r;

  logic        cfg_wr;
  logic [1:0]  cfg_idx;
  logic        accept;
  logic        changed;
  logic        step;
  logic        buf_full;
  logic [7:0]  edges;
  logic [CNT_W-1:0] counts [8];
  gmed_out_t   result;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  // Register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 8'h00;
      rising_r  <= 8'hFF;
      always_r  <= 8'hFF;
      links_r   <= 64'd0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLED: enabled_r <= cfg_pwdata[7:0];
        REG_RISING:  rising_r  <= cfg_pwdata[7:0];
        REG_ALWAYS:  always_r  <= cfg_pwdata[7:0];
        REG_LINKS:   links_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_ENABLED: cfg_prdata = {56'd0, enabled_r};
      REG_RISING:  cfg_prdata = {56'd0, rising_r};
      REG_ALWAYS:  cfg_prdata = {56'd0, always_r};
      REG_LINKS:   cfg_prdata = links_r;
      default:     cfg_prdata = 64'd0;
    endcase
  end

  // Poll acceptance and change detection
  assign in_stall = buf_full;
  assign accept   = in_valid & ~buf_full;
  assign changed  = ~hist_valid_r | (in_data.input_levels != last_in_r) |
                    (in_data.output_levels != last_out_r);
  assign step     = accept & changed & hist_valid_r;

  // History
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      hist_valid_r <= 1'b0;
    end else if (accept && changed) begin
      hist_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && changed) begin
      last_in_r  <= in_data.input_levels;
      last_out_r <= in_data.output_levels;
    end
  end

  // Channel lanes
  for (genvar i = 0; i < 8; i++) begin : g_lane
    if (i < IN_CH) begin : g_on
      gmed_lane_cfg_t lcfg;
      gmed_lane_ctl_t lctl;
      logic           hit;

      assign lcfg.enabled    = enabled_r[i] & IN_MASK[i];
      assign lcfg.rising     = rising_r[i];
      assign lcfg.always_on  = always_r[i];
      assign lcfg.links      = links_r[8*i +: 8];
      assign lctl.clear      = cfg_wr;
      assign lctl.step       = step;
      assign lctl.cur_level  = in_data.input_levels[i];
      assign lctl.last_level = last_in_r[i];

      gmed_lane u_lane (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (lcfg),
        .ctl           (lctl),
        .output_levels (in_data.output_levels),
        .edge_hit      (hit),
        .count         (counts[i])
      );

      assign edges[i] = hit & changed & hist_valid_r;
    end else begin : g_off
      assign edges[i]  = 1'b0;
      assign counts[i] = '0;
    end
  end

  // Merge lane results
  assign result.changed        = changed;
  assign result.edge_mask      = edges;
  assign result.edge_count_ch0 = cnt_field(counts[0]);
  assign result.edge_count_ch1 = cnt_field(counts[1]);
  assign result.edge_count_ch2 = cnt_field(counts[2]);
  assign result.edge_count_ch3 = cnt_field(counts[3]);
  assign result.edge_count_ch4 = cnt_field(counts[4]);
  assign result.edge_count_ch5 = cnt_field(counts[5]);
  assign result.edge_count_ch6 = cnt_field(counts[6]);
  assign result.edge_count_ch7 = cnt_field(counts[7]);

  // Output buffer
  gmed_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
